>>> sv/ctok_pkg.sv
// ============================================================================
// ctok_pkg
// Shared types, token codes and character classifiers for the C subset
// tokenizer.
// ============================================================================
package ctok_pkg;

  // Width of the line number carried in each record.
  localparam int LINE_OUT_W = 24;
  // Width of the start line configuration register.
  localparam int CFG_W = 24;
  // Default line counter width and queue depth.
  localparam int LINE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 4;
  // Reset value of the start line register.
  localparam logic [CFG_W-1:0] START_LINE_RST = CFG_W'(1);

  // Token kind codes.
  localparam logic [5:0] K_COMMENT  = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_NUM      = 6'd2;
  localparam logic [5:0] K_STR      = 6'd3;
  localparam logic [5:0] K_CHR      = 6'd4;
  localparam logic [5:0] K_COMMA    = 6'd5;
  localparam logic [5:0] K_SEMI     = 6'd6;
  localparam logic [5:0] K_LPAREN   = 6'd7;
  localparam logic [5:0] K_RPAREN   = 6'd8;
  localparam logic [5:0] K_LBRACKET = 6'd9;
  localparam logic [5:0] K_RBRACKET = 6'd10;
  localparam logic [5:0] K_LBRACE   = 6'd11;
  localparam logic [5:0] K_RBRACE   = 6'd12;
  localparam logic [5:0] K_DOT      = 6'd13;
  localparam logic [5:0] K_STAR     = 6'd14;
  localparam logic [5:0] K_SLASH    = 6'd15;
  localparam logic [5:0] K_CARET    = 6'd16;
  localparam logic [5:0] K_PERCENT  = 6'd17;
  localparam logic [5:0] K_TILDE    = 6'd18;
  localparam logic [5:0] K_ARROW    = 6'd19;
  localparam logic [5:0] K_SHL      = 6'd20;
  localparam logic [5:0] K_SHR      = 6'd21;
  localparam logic [5:0] K_ASSIGN   = 6'd22;
  localparam logic [5:0] K_EQ       = 6'd23;
  localparam logic [5:0] K_NOT      = 6'd24;
  localparam logic [5:0] K_NE       = 6'd25;
  localparam logic [5:0] K_LT       = 6'd26;
  localparam logic [5:0] K_LE       = 6'd27;
  localparam logic [5:0] K_GT       = 6'd28;
  localparam logic [5:0] K_GE       = 6'd29;
  localparam logic [5:0] K_PLUS     = 6'd30;
  localparam logic [5:0] K_INC      = 6'd31;
  localparam logic [5:0] K_MINUS    = 6'd32;
  localparam logic [5:0] K_DEC      = 6'd33;
  localparam logic [5:0] K_OR       = 6'd34;
  localparam logic [5:0] K_LOR      = 6'd35;
  localparam logic [5:0] K_AND      = 6'd36;
  localparam logic [5:0] K_LAND     = 6'd37;
  localparam logic [5:0] K_UNKNOWN  = 6'd39;
  localparam logic [5:0] K_DONE     = 6'd40;
  // Marker for "no such token".
  localparam logic [5:0] K_NONE     = 6'd63;

  // Characters with special meaning.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Lexer mode.
  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_OP        = 4'd1,
    M_IDENT     = 4'd2,
    M_NUM       = 4'd3,
    M_STR       = 4'd4,
    M_STR_ESC   = 4'd5,
    M_CHR_FIRST = 4'd6,
    M_CHR_ESC   = 4'd7,
    M_CHR_CLOSE = 4'd8,
    M_BLOCK     = 4'd9,
    M_LINE      = 4'd10
  } lex_mode_t;

  // One result record without its line number and run marker.
  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] value;
    logic       has_byte;
    logic       tok_end;
    logic       unterm;
  } rec_t;

  // All records caused by one input beat, sharing one line number.
  typedef struct packed {
    logic [1:0]            cnt;
    logic [LINE_OUT_W-1:0] line;
    rec_t [2:0]            recs;
  } bundle_t;

  function automatic rec_t mk_rec(input logic [5:0] kind, input logic [7:0] value,
                                  input logic has, input logic fin, input logic unterm);
    rec_t r;
    r.kind     = kind;
    r.value    = has ? value : 8'd0;
    r.has_byte = has;
    r.tok_end  = fin;
    r.unterm   = unterm;
    return r;
  endfunction

  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha_char(c) || is_dec_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_dec_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
        || ((c >= 8'h41) && (c <= 8'h46)) || (c == 8'h78) || (c == 8'h58);
  endfunction

  // Translate the byte after a backslash.
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h72:   r = 8'd13;
      8'h6E:   r = 8'd10;
      8'h74:   r = 8'd9;
      8'h30:   r = 8'd0;
      default: r = c;
    endcase
    return r;
  endfunction

  // Kind of a character that never combines with the next one.
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h2C:   k = K_COMMA;
      8'h3B:   k = K_SEMI;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h5B:   k = K_LBRACKET;
      8'h5D:   k = K_RBRACKET;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h2E:   k = K_DOT;
      8'h2A:   k = K_STAR;
      8'h5E:   k = K_CARET;
      8'h25:   k = K_PERCENT;
      8'h7E:   k = K_TILDE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // One-character kind of a character that may start a pair.
  function automatic logic [5:0] op_base(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h2F:   k = K_SLASH;
      8'h3D:   k = K_ASSIGN;
      8'h21:   k = K_NOT;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h7C:   k = K_OR;
      8'h26:   k = K_AND;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Two-character kind for first byte f and second byte s.
  function automatic logic [5:0] op_pair(input logic [7:0] f, input logic [7:0] s);
    logic [5:0] k;
    k = K_NONE;
    unique case (f)
      8'h2D:   k = (s == 8'h3E) ? K_ARROW : ((s == 8'h2D) ? K_DEC : K_NONE);
      8'h3C:   k = (s == 8'h3C) ? K_SHL : ((s == 8'h3D) ? K_LE : K_NONE);
      8'h3E:   k = (s == 8'h3E) ? K_SHR : ((s == 8'h3D) ? K_GE : K_NONE);
      8'h3D:   k = (s == 8'h3D) ? K_EQ : K_NONE;
      8'h21:   k = (s == 8'h3D) ? K_NE : K_NONE;
      8'h2B:   k = (s == 8'h2B) ? K_INC : K_NONE;
      8'h7C:   k = (s == 8'h7C) ? K_LOR : K_NONE;
      8'h26:   k = (s == 8'h26) ? K_LAND : K_NONE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> sv/ctok_front.sv
// ============================================================================
// ctok_front
// Lexer front end: takes one source byte per beat, advances the lexer state
// and the line counter, and hands all records of that beat to the queue as
// one bundle.
// ============================================================================
module ctok_front import ctok_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_end_of_input,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_start_line,
  input  logic             q_full,
  output logic             push,
  output bundle_t          push_bundle
);

  localparam int CMP_W = (LINE_BITS > CFG_W) ? LINE_BITS : CFG_W;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  lex_mode_t            mode_r, mode_nxt;
  logic [7:0]           held_r, held_nxt;
  logic [5:0]           kind_r, kind_nxt;
  logic                 star_r, star_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [CFG_W-1:0]     start_r;

  logic                 accept;
  logic [LINE_BITS-1:0] line_bumped;

  // Start-of-token decode of the current byte.
  lex_mode_t  sb_mode;
  logic       sb_set_held;
  logic       sb_set_kind;
  logic [5:0] sb_kind;
  logic       sb_bump;
  logic [1:0] sb_n;
  rec_t       sb_rec0, sb_rec1;
  logic [5:0] sb_op, sb_single;

  rec_t       recs_v [3];
  logic [1:0] n_v;
  logic       do_start;
  logic [5:0] pair_k;

  // Clip a start line to the counter range.
  function automatic logic [LINE_BITS-1:0] clip_line(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] mx;
    ext = CMP_W'(v);
    mx  = CMP_W'(LINE_MAX);
    return (ext > mx) ? LINE_MAX : LINE_BITS'(ext);
  endfunction

  assign accept      = in_valid && in_ready;
  assign in_ready    = !q_full;
  assign line_bumped = (line_r != LINE_MAX) ? line_r + LINE_BITS'(1) : line_r;

  // Classify a byte that begins a new token.
  always_comb begin
    sb_op       = op_base(in_byte);
    sb_single   = single_kind(in_byte);
    sb_mode     = M_IDLE;
    sb_set_held = 1'b0;
    sb_set_kind = 1'b0;
    sb_kind     = K_COMMENT;
    sb_bump     = 1'b0;
    sb_n        = 2'd0;
    sb_rec0     = '0;
    sb_rec1     = '0;
    if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR || in_byte == CH_NL) begin
      sb_bump = (in_byte == CH_NL);
    end else if (sb_op != K_NONE) begin
      sb_mode     = M_OP;
      sb_set_held = 1'b1;
    end else if (is_alpha_char(in_byte) || in_byte == CH_UNDER) begin
      sb_mode     = M_IDENT;
      sb_set_kind = 1'b1;
      sb_kind     = K_IDENT;
      sb_n        = 2'd1;
      sb_rec0     = mk_rec(K_IDENT, in_byte, 1'b1, 1'b0, 1'b0);
    end else if (is_dec_digit(in_byte)) begin
      sb_mode     = M_NUM;
      sb_set_kind = 1'b1;
      sb_kind     = K_NUM;
      sb_n        = 2'd1;
      sb_rec0     = mk_rec(K_NUM, in_byte, 1'b1, 1'b0, 1'b0);
    end else if (in_byte == CH_DQUOTE) begin
      sb_mode     = M_STR;
      sb_set_kind = 1'b1;
      sb_kind     = K_STR;
    end else if (in_byte == CH_SQUOTE) begin
      sb_mode     = M_CHR_FIRST;
      sb_set_kind = 1'b1;
      sb_kind     = K_CHR;
    end else if (sb_single != K_NONE) begin
      sb_n    = 2'd1;
      sb_rec0 = mk_rec(sb_single, 8'd0, 1'b0, 1'b1, 1'b0);
    end else begin
      // Unknown byte: its own value record, then the token end.
      sb_n    = 2'd2;
      sb_rec0 = mk_rec(K_UNKNOWN, in_byte, 1'b1, 1'b0, 1'b0);
      sb_rec1 = mk_rec(K_UNKNOWN, 8'd0, 1'b0, 1'b1, 1'b0);
    end
  end

  // Lexer step for one accepted beat.
  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    kind_nxt  = kind_r;
    star_nxt  = star_r;
    line_nxt  = line_r;
    recs_v[0] = '0;
    recs_v[1] = '0;
    recs_v[2] = '0;
    n_v       = 2'd0;
    do_start  = 1'b0;
    pair_k    = op_pair(held_r, in_byte);
    if (accept) begin
      if (in_end_of_input) begin
        // Flush the pending token, then DONE.
        unique case (mode_r)
          M_IDLE: begin
          end
          M_OP: begin
            recs_v[n_v] = mk_rec(op_base(held_r), 8'd0, 1'b0, 1'b1, 1'b0);
            n_v = n_v + 2'd1;
          end
          M_IDENT, M_NUM: begin
            recs_v[n_v] = mk_rec(kind_r, 8'd0, 1'b0, 1'b1, 1'b0);
            n_v = n_v + 2'd1;
          end
          M_BLOCK, M_LINE: begin
            recs_v[n_v] = mk_rec(K_COMMENT, 8'd0, 1'b0, 1'b1, 1'b1);
            n_v = n_v + 2'd1;
          end
          default: begin
            recs_v[n_v] = mk_rec(kind_r, 8'd0, 1'b0, 1'b1, 1'b1);
            n_v = n_v + 2'd1;
          end
        endcase
        recs_v[n_v] = mk_rec(K_DONE, 8'd0, 1'b0, 1'b1, 1'b0);
        n_v = n_v + 2'd1;
        mode_nxt = M_IDLE;
        held_nxt = 8'd0;
        kind_nxt = K_COMMENT;
        star_nxt = 1'b0;
        line_nxt = clip_line(start_r);
      end else begin
        unique case (mode_r)
          M_OP: begin
            mode_nxt = M_IDLE;
            if (held_r == CH_SLASH && in_byte == CH_STAR) begin
              mode_nxt = M_BLOCK;
              star_nxt = 1'b0;
            end else if (held_r == CH_SLASH && in_byte == CH_SLASH) begin
              mode_nxt = M_LINE;
            end else if (pair_k != K_NONE) begin
              recs_v[n_v] = mk_rec(pair_k, 8'd0, 1'b0, 1'b1, 1'b0);
              n_v = n_v + 2'd1;
            end else begin
              recs_v[n_v] = mk_rec(op_base(held_r), 8'd0, 1'b0, 1'b1, 1'b0);
              n_v = n_v + 2'd1;
              do_start = 1'b1;
            end
          end
          M_IDENT, M_NUM: begin
            if ((mode_r == M_IDENT) ? is_ident_char(in_byte) : is_num_char(in_byte)) begin
              recs_v[n_v] = mk_rec(kind_r, in_byte, 1'b1, 1'b0, 1'b0);
              n_v = n_v + 2'd1;
            end else begin
              recs_v[n_v] = mk_rec(kind_r, 8'd0, 1'b0, 1'b1, 1'b0);
              n_v = n_v + 2'd1;
              mode_nxt = M_IDLE;
              do_start = 1'b1;
            end
          end
          M_STR: begin
            if (in_byte == CH_DQUOTE) begin
              recs_v[n_v] = mk_rec(K_STR, 8'd0, 1'b0, 1'b1, 1'b0);
              n_v = n_v + 2'd1;
              mode_nxt = M_IDLE;
            end else if (in_byte == CH_BSLASH) begin
              mode_nxt = M_STR_ESC;
            end else begin
              recs_v[n_v] = mk_rec(K_STR, in_byte, 1'b1, 1'b0, 1'b0);
              n_v = n_v + 2'd1;
            end
          end
          M_STR_ESC: begin
            recs_v[n_v] = mk_rec(K_STR, unescape(in_byte), 1'b1, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
            mode_nxt = M_STR;
          end
          M_CHR_FIRST: begin
            if (in_byte == CH_BSLASH) begin
              mode_nxt = M_CHR_ESC;
            end else begin
              recs_v[n_v] = mk_rec(K_CHR, in_byte, 1'b1, 1'b0, 1'b0);
              n_v = n_v + 2'd1;
              mode_nxt = M_CHR_CLOSE;
            end
          end
          M_CHR_ESC: begin
            recs_v[n_v] = mk_rec(K_CHR, unescape(in_byte), 1'b1, 1'b0, 1'b0);
            n_v = n_v + 2'd1;
            mode_nxt = M_CHR_CLOSE;
          end
          M_CHR_CLOSE: begin
            // The closing quote is taken whatever byte it is.
            recs_v[n_v] = mk_rec(K_CHR, 8'd0, 1'b0, 1'b1, 1'b0);
            n_v = n_v + 2'd1;
            mode_nxt = M_IDLE;
          end
          M_BLOCK: begin
            if (star_r && in_byte == CH_SLASH) begin
              star_nxt = 1'b0;
              recs_v[n_v] = mk_rec(K_COMMENT, 8'd0, 1'b0, 1'b1, 1'b0);
              n_v = n_v + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              if (in_byte == CH_NL) begin
                line_nxt = line_bumped;
              end
              star_nxt = (in_byte == CH_STAR);
            end
          end
          M_LINE: begin
            if (in_byte == CH_NL) begin
              recs_v[n_v] = mk_rec(K_COMMENT, 8'd0, 1'b0, 1'b1, 1'b0);
              n_v = n_v + 2'd1;
              mode_nxt = M_IDLE;
              do_start = 1'b1;
            end
          end
          default: begin
            mode_nxt = M_IDLE;
            do_start = 1'b1;
          end
        endcase

        // The current byte starts a new token.
        if (do_start) begin
          mode_nxt = sb_mode;
          if (sb_set_held) begin
            held_nxt = in_byte;
          end
          if (sb_set_kind) begin
            kind_nxt = sb_kind;
          end
          if (sb_bump) begin
            line_nxt = line_bumped;
          end
          if (sb_n != 2'd0) begin
            recs_v[n_v] = sb_rec0;
            n_v = n_v + 2'd1;
          end
          if (sb_n == 2'd2) begin
            recs_v[n_v] = sb_rec1;
            n_v = n_v + 2'd1;
          end
        end
      end
    end
  end

  // Bundle toward the queue; all records of a beat carry the line before it.
  always_comb begin
    push_bundle.cnt     = n_v;
    push_bundle.line    = LINE_OUT_W'(line_r);
    push_bundle.recs[0] = recs_v[0];
    push_bundle.recs[1] = recs_v[1];
    push_bundle.recs[2] = recs_v[2];
    push                = accept && (n_v != 2'd0);
  end

  // Lexer state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      held_r  <= 8'd0;
      kind_r  <= K_COMMENT;
      star_r  <= 1'b0;
      start_r <= START_LINE_RST;
      line_r  <= clip_line(START_LINE_RST);
    end else begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      kind_r <= kind_nxt;
      star_r <= star_nxt;
      if (cfg_we) begin
        start_r <= cfg_start_line;
        line_r  <= clip_line(cfg_start_line);
      end else begin
        line_r <= line_nxt;
      end
    end
  end

  // A beat is never taken while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push) else $error("push into a full queue");

  // The line count only steps by one, holds, or reloads at end of input or on a cfg_we write.
  a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_end_of_input && !cfg_we) |=>
      (line_r == $past(line_r)) || (line_r == $past(line_r) + LINE_BITS'(1)))
    else $error("line count jumped");

endmodule

>>> sv/ctok_queue.sv
// ============================================================================
// ctok_queue
// Short FIFO of record bundles between the lexer front end and the record
// serializer.
// ============================================================================
module ctok_queue import ctok_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output bundle_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  bundle_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != CNT_W'(0));
  assign head      = slot_r[rd_ptr_r];

  // Bundle storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bundle;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Fill count stays in range and is never popped below empty.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from an empty queue");

endmodule

>>> sv/ctok_back.sv
// ============================================================================
// ctok_back
// Record serializer: walks the records of the bundle at the head of the
// queue and moves them one per beat into the output register.
// ============================================================================
module ctok_back import ctok_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  bundle_t               q_head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_token_kind,
  output logic [7:0]            out_value_byte,
  output logic                  out_has_byte,
  output logic                  out_token_end,
  output logic [LINE_OUT_W-1:0] out_line_number,
  output logic                  out_unterminated,
  output logic                  out_run_last
);

  logic [1:0]            sub_r, sub_nxt;
  logic                  valid_r, valid_nxt;
  rec_t                  rec_r;
  logic [LINE_OUT_W-1:0] line_r;
  logic                  last_r;
  logic                  load;
  logic                  is_last;
  rec_t                  cur;

  assign cur     = q_head.recs[sub_r];
  assign is_last = (sub_r == q_head.cnt - 2'd1);
  assign load    = q_not_empty && (!valid_r || out_ready);
  assign pop     = load && is_last;

  // Record index within the head bundle and output valid.
  always_comb begin
    sub_nxt   = sub_r;
    valid_nxt = valid_r;
    if (load) begin
      sub_nxt   = is_last ? 2'd0 : sub_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= cur;
      line_r <= q_head.line;
      last_r <= is_last;
    end
  end

  assign out_valid        = valid_r;
  assign out_token_kind   = rec_r.kind;
  assign out_value_byte   = rec_r.value;
  assign out_has_byte     = rec_r.has_byte;
  assign out_token_end    = rec_r.tok_end;
  assign out_line_number  = line_r;
  assign out_unterminated = rec_r.unterm;
  assign out_run_last     = last_r;

  // The record index never runs past the bundle it walks.
  a_sub_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty |-> (sub_r < q_head.cnt)) else $error("record index past bundle");

endmodule

>>> sv/c_subset_tokenizer.sv
// ============================================================================
// c_subset_tokenizer
// Streaming lexer for a subset of C: source bytes in, token records out.
// ============================================================================
// Usage:
//   Source bytes enter on the in_ channel (valid/ready), one byte per beat;
//   a beat with in_end_of_input high flushes the pending token, emits a
//   DONE record and reloads the line count from the stored start line.
//   Each input beat yields zero to three records on the out_ channel
//   (valid/ready); out_run_last marks the last record of a beat.
//   cfg_we writes the start line and loads the line count at once; write it
//   only while no beat is in flight.
//   The records of a beat pass through the bundle queue and then the output
//   register. Throughput: one input beat per cycle while the queue is not
//   full, and one record per cycle on the output while out_ready is high;
//   the output register is the limit and passes a beat's records in turn.
//   A bundle queue of QUEUE_DEPTH entries sits between lexer and output.
//   When the receiver stalls, records hold in the output register and the
//   queue fills; in_ready drops only when the queue is full.
//   Synchronous reset clears the lexer to idle, sets the start line to 1
//   and empties the queue and output register.
// ============================================================================
module c_subset_tokenizer import ctok_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_input,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_start_line,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_token_kind,
  output logic [7:0]            out_value_byte,
  output logic                  out_has_byte,
  output logic                  out_token_end,
  output logic [LINE_OUT_W-1:0] out_line_number,
  output logic                  out_unterminated,
  output logic                  out_run_last
);

  logic    q_push, q_pop, q_full, q_not_empty;
  bundle_t q_in, q_head;

  // Lexer front end.
  ctok_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_input(in_end_of_input),
    .cfg_we         (cfg_we),
    .cfg_start_line (cfg_start_line),
    .q_full         (q_full),
    .push           (q_push),
    .push_bundle    (q_in)
  );

  // Bundle queue.
  ctok_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_bundle(q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Record serializer and output register.
  ctok_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_value_byte  (out_value_byte),
    .out_has_byte    (out_has_byte),
    .out_token_end   (out_token_end),
    .out_line_number (out_line_number),
    .out_unterminated(out_unterminated),
    .out_run_last    (out_run_last)
  );

endmodule
